// ----- hw/rtl/psgc_pkg.sv -----
// Shared types, constants and tables of the sound channel core.
package psgc_pkg;

    localparam int NOISE_CAPABLE = 1;
    localparam int WAVE_DEPTH    = 32;

    localparam logic [31:0] NOISE_SEED = 32'h51F63101;
    localparam logic [31:0] NOISE_TAP  = 32'h00080000;
    localparam logic [31:0] NOISE_XOR  = 32'h00000004;

    localparam int DIV_W  = 25;
    localparam int DVS_W  = 17;
    localparam int REM_W  = 18;
    localparam int CNT_W  = 5;

    localparam logic [2:0] CFG_PERIOD   = 3'd0;
    localparam logic [2:0] CFG_CTRL     = 3'd1;
    localparam logic [2:0] CFG_BALANCE  = 3'd2;
    localparam logic [2:0] CFG_NOISE    = 3'd3;
    localparam logic [2:0] CFG_MAIN_VOL = 3'd4;
    localparam logic [2:0] CFG_STEREO   = 3'd5;
    localparam logic [2:0] CFG_RATIO    = 3'd6;
    localparam logic [2:0] CFG_RATE     = 3'd7;

    localparam logic [1:0] POL_SILENT = 2'd0;
    localparam logic [1:0] POL_POS    = 2'd1;
    localparam logic [1:0] POL_NEG    = 2'd2;

    localparam logic [17:0] NOISE_BASE  = 18'd3000;
    localparam logic [12:0] NOISE_AMPL  = 13'd7020;
    localparam logic [6:0]  VOL_OFFSET  = 7'd60;
    localparam logic [12:0] RECIP_10    = 13'd6554;
    localparam logic [12:0] RECIP_100   = 13'd5243;

    typedef struct packed {
        logic wr_en;
        logic div_start;
        logic div_noise;
        logic clr_phase;
        logic zero_res;
        logic noise_fin;
        logic w1;
        logic w2;
        logic w3;
        logic w4;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic enabled;
        logic noise;
        logic direct;
        logic per_zero;
        logic div_done;
        logic div_busy;
        logic out_free;
    } t_status;

    function automatic logic [6:0] level_lookup(input logic [4:0] idx);
        logic [6:0] v;
        unique case (idx)
            5'd0:  v = 7'd0;   5'd1:  v = 7'd1;   5'd2:  v = 7'd1;   5'd3:  v = 7'd2;
            5'd4:  v = 7'd2;   5'd5:  v = 7'd2;   5'd6:  v = 7'd3;   5'd7:  v = 7'd3;
            5'd8:  v = 7'd4;   5'd9:  v = 7'd4;   5'd10: v = 7'd5;   5'd11: v = 7'd5;
            5'd12: v = 7'd6;   5'd13: v = 7'd7;   5'd14: v = 7'd8;   5'd15: v = 7'd9;
            5'd16: v = 7'd10;  5'd17: v = 7'd11;  5'd18: v = 7'd13;  5'd19: v = 7'd15;
            5'd20: v = 7'd17;  5'd21: v = 7'd19;  5'd22: v = 7'd21;  5'd23: v = 7'd24;
            5'd24: v = 7'd27;  5'd25: v = 7'd31;  5'd26: v = 7'd35;  5'd27: v = 7'd39;
            5'd28: v = 7'd44;  5'd29: v = 7'd50;  5'd30: v = 7'd56;  default: v = 7'd64;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/psgc_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
module psgc_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [psgc_pkg::DIV_W-1:0]   i_dividend,
    input  logic [psgc_pkg::DVS_W-1:0]   i_divisor,
    output logic                         o_busy,
    output logic                         o_done,
    output logic [psgc_pkg::DIV_W-1:0]   o_quo,
    output logic [psgc_pkg::REM_W-1:0]   o_rem
);
    logic [psgc_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic                       r_busy, n_busy;
    logic                       r_done, n_done;
    logic [psgc_pkg::DIV_W-1:0] r_quo, n_quo;
    logic [psgc_pkg::REM_W-1:0] r_rem, n_rem;
    logic [psgc_pkg::DVS_W-1:0] r_dvs, n_dvs;
    logic [psgc_pkg::REM_W-1:0] rem_sh;
    logic                       fits;

    assign rem_sh = {r_rem[psgc_pkg::REM_W-2:0], r_quo[psgc_pkg::DIV_W-1]};
    assign fits   = rem_sh >= {1'b0, r_dvs};

    always_comb begin
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_cnt  = psgc_pkg::CNT_W'(psgc_pkg::DIV_W - 1);
            n_busy = 1'b1;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            n_rem = fits ? rem_sh - {1'b0, r_dvs} : rem_sh;
            n_quo = {r_quo[psgc_pkg::DIV_W-2:0], fits};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule

// ----- hw/rtl/psgc_dp.sv -----
// Datapath: configuration, waveform table, phase and noise state, arithmetic.
module psgc_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_idx,
    input  logic [16:0]           i_cfg_data,
    input  logic [4:0]            i_wave_addr,
    input  logic [4:0]            i_wave_value,
    input  logic                  i_out_ready,
    input  psgc_pkg::t_cmd        i_cmd,
    output psgc_pkg::t_status     o_status,
    output logic                  o_out_valid,
    output logic signed [7:0]     o_left_sample,
    output logic signed [7:0]     o_right_sample
);
    logic [11:0] r_period;
    logic [7:0]  r_cc, r_bal, r_nc, r_mv;
    logic        r_stereo;
    logic [8:0]  r_ratio;
    logic [16:0] r_rate;

    logic [4:0]  r_table [psgc_pkg::WAVE_DEPTH];
    logic [20:0] r_phase;
    logic [4:0]  r_pos;
    logic [16:0] r_nacc;
    logic [31:0] r_lfsr;
    logic [1:0]  r_pol;

    logic [4:0]  r_smag;
    logic        r_sneg;
    logic [12:0] r_lp, r_rp;
    logic [8:0]  r_lbal, r_rbal;
    logic [13:0] r_pl, r_pr;
    logic [7:0]  r_res_l, r_res_r;
    logic        r_out_valid;
    logic [7:0]  r_out_l, r_out_r;

    logic [17:0] nsum;
    logic [16:0] nrate;
    logic [24:0] dividend;
    logic [16:0] divisor;
    logic        div_busy, div_done;
    logic [24:0] quo;
    logic [17:0] rem;

    logic [5:0]  mv_max, bal_max;
    logic [6:0]  vsum;
    logic [4:0]  vidx;
    logic [6:0]  nvol;
    logic        step;
    logic [31:0] lfsr_nx;
    logic [1:0]  pol_nx;
    logic [19:0] nprod;
    logic [7:0]  nmag;
    logic [4:0]  entry;
    logic [8:0]  lnib_vol, rnib_vol;
    logic [25:0] lq10, rq10;
    logic [8:0]  bal_m;
    logic [26:0] lq100, rq100;
    logic [7:0]  lmag, rmag;
    logic [20:0] phase_nx;

    assign nsum     = {1'b0, r_nacc} + psgc_pkg::NOISE_BASE + {4'd0, r_nc[4:0], 9'd0};
    assign nrate    = (r_rate == '0) ? 17'd1 : r_rate;
    assign dividend = i_cmd.div_noise ? {7'd0, nsum} : {r_ratio, 16'd0};
    assign divisor  = i_cmd.div_noise ? nrate : {5'd0, r_period};

    psgc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend),
        .i_divisor  (divisor),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quo      (quo),
        .o_rem      (rem)
    );

    always_comb begin
        mv_max   = ({1'b0, r_mv[7:4], 1'b0} > {1'b0, r_mv[3:0], 1'b0}) ?
                   {1'b0, r_mv[7:4], 1'b0} : {1'b0, r_mv[3:0], 1'b0};
        bal_max  = ({1'b0, r_bal[7:4], 1'b0} > {1'b0, r_bal[3:0], 1'b0}) ?
                   {1'b0, r_bal[7:4], 1'b0} : {1'b0, r_bal[3:0], 1'b0};
        vsum     = {1'b0, mv_max} + {2'd0, r_cc[4:0]} + {1'b0, bal_max};
        vidx     = (vsum > psgc_pkg::VOL_OFFSET) ? 5'(vsum - psgc_pkg::VOL_OFFSET) : 5'd0;
        nvol     = psgc_pkg::level_lookup(vidx);
        step     = (quo != '0);
        if (!step) begin
            lfsr_nx = r_lfsr;
            pol_nx  = r_pol;
        end else if ((r_lfsr & psgc_pkg::NOISE_TAP) != '0) begin
            lfsr_nx = ((r_lfsr ^ psgc_pkg::NOISE_XOR) << 1) | 32'd1;
            pol_nx  = psgc_pkg::POL_NEG;
        end else begin
            lfsr_nx = r_lfsr << 1;
            pol_nx  = psgc_pkg::POL_POS;
        end
        nprod    = {7'd0, psgc_pkg::NOISE_AMPL} * {13'd0, nvol};
        nmag     = {1'b0, nprod[18:12]};
        entry    = r_table[r_pos];
        lnib_vol = {5'd0, r_bal[7:4]} * {4'd0, r_cc[4:0]};
        rnib_vol = {5'd0, r_bal[3:0]} * {4'd0, r_cc[4:0]};
        lq10     = {13'd0, r_lp} * {13'd0, psgc_pkg::RECIP_10};
        rq10     = {13'd0, r_rp} * {13'd0, psgc_pkg::RECIP_10};
        bal_m    = 9'(({1'b0, r_lbal} + {1'b0, r_rbal}) >> 1);
        lq100    = {13'd0, r_pl} * {14'd0, psgc_pkg::RECIP_100};
        rq100    = {13'd0, r_pr} * {14'd0, psgc_pkg::RECIP_100};
        lmag     = lq100[26:19];
        rmag     = rq100[26:19];
        phase_nx = r_phase + quo[20:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= '0;
            r_cc        <= '0;
            r_bal       <= '0;
            r_nc        <= '0;
            r_mv        <= '0;
            r_stereo    <= 1'b1;
            r_ratio     <= 9'd81;
            r_rate      <= 17'd44100;
            for (int i = 0; i < psgc_pkg::WAVE_DEPTH; i++) begin
                r_table[i] <= '0;
            end
            r_phase     <= '0;
            r_pos       <= '0;
            r_nacc      <= '0;
            r_lfsr      <= (psgc_pkg::NOISE_CAPABLE != 0) ? psgc_pkg::NOISE_SEED : 32'd0;
            r_pol       <= psgc_pkg::POL_SILENT;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    psgc_pkg::CFG_PERIOD:   r_period <= i_cfg_data[11:0];
                    psgc_pkg::CFG_CTRL:     r_cc     <= i_cfg_data[7:0];
                    psgc_pkg::CFG_BALANCE:  r_bal    <= i_cfg_data[7:0];
                    psgc_pkg::CFG_NOISE:    r_nc     <= i_cfg_data[7:0];
                    psgc_pkg::CFG_MAIN_VOL: r_mv     <= i_cfg_data[7:0];
                    psgc_pkg::CFG_STEREO:   r_stereo <= i_cfg_data[0];
                    psgc_pkg::CFG_RATIO:    r_ratio  <= i_cfg_data[8:0];
                    psgc_pkg::CFG_RATE:     r_rate   <= i_cfg_data;
                    default:                r_rate   <= r_rate;
                endcase
            end
            if (i_cmd.wr_en) begin
                r_table[i_wave_addr] <= i_wave_value;
            end
            if (i_cmd.clr_phase) begin
                r_phase <= '0;
            end
            if (i_cmd.noise_fin) begin
                r_nacc <= rem[16:0];
                r_lfsr <= lfsr_nx;
                r_pol  <= pol_nx;
            end
            if (i_cmd.w4) begin
                r_phase <= phase_nx;
                r_pos   <= phase_nx[20:16];
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.zero_res) begin
            r_res_l <= '0;
            r_res_r <= '0;
        end
        if (i_cmd.noise_fin) begin
            priority case (pol_nx)
                psgc_pkg::POL_POS: begin
                    r_res_l <= nmag;
                    r_res_r <= nmag;
                end
                psgc_pkg::POL_NEG: begin
                    r_res_l <= 8'(-nmag);
                    r_res_r <= 8'(-nmag);
                end
                default: begin
                    r_res_l <= '0;
                    r_res_r <= '0;
                end
            endcase
        end
        if (i_cmd.w1) begin
            r_sneg <= ~entry[4];
            r_smag <= entry[4] ? entry - 5'd15 : 5'd16 - entry;
            r_lp   <= 13'({4'd0, lnib_vol} * 13'd11);
            r_rp   <= 13'({4'd0, rnib_vol} * 13'd11);
        end
        if (i_cmd.w2) begin
            r_lbal <= lq10[24:16];
            r_rbal <= rq10[24:16];
        end
        if (i_cmd.w3) begin
            if (r_stereo) begin
                r_pl <= {9'd0, r_smag} * {5'd0, r_lbal};
                r_pr <= {9'd0, r_smag} * {5'd0, r_rbal};
            end else begin
                r_pl <= {9'd0, r_smag} * {5'd0, bal_m};
                r_pr <= '0;
            end
        end
        if (i_cmd.w4) begin
            r_res_l <= r_sneg ? 8'(-lmag) : lmag;
            r_res_r <= r_sneg ? 8'(-rmag) : rmag;
        end
        if (i_cmd.load_out) begin
            r_out_l <= r_res_l;
            r_out_r <= r_res_r;
        end
    end

    assign o_status.enabled  = r_cc[7];
    assign o_status.noise    = (psgc_pkg::NOISE_CAPABLE != 0) && r_nc[7];
    assign o_status.direct   = r_cc[6];
    assign o_status.per_zero = (r_period == '0);
    assign o_status.div_done = div_done;
    assign o_status.div_busy = div_busy;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_left_sample  = r_out_l;
    assign o_right_sample = r_out_r;
endmodule

// ----- hw/rtl/psgc_ctrl.sv -----
// Controller state machine that sequences each item through the datapath.
module psgc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_kind,
    input  psgc_pkg::t_status i_status,
    output logic              o_in_ready,
    output psgc_pkg::t_cmd    o_cmd
);
    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_DIV  = 8'b0000_0010,
        ST_NZ   = 8'b0000_0100,
        ST_W1   = 8'b0000_1000,
        ST_W2   = 8'b0001_0000,
        ST_W3   = 8'b0010_0000,
        ST_W4   = 8'b0100_0000,
        ST_DONE = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_is_noise, n_is_noise;
    logic   accept;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state    = r_state;
        n_is_noise = r_is_noise;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && !i_kind) begin
                    o_cmd.wr_en = 1'b1;
                end else if (accept) begin
                    priority if (!i_status.enabled) begin
                        o_cmd.clr_phase = 1'b1;
                        o_cmd.zero_res  = 1'b1;
                        n_state         = ST_DONE;
                    end else if (i_status.noise) begin
                        o_cmd.div_start = 1'b1;
                        o_cmd.div_noise = 1'b1;
                        n_is_noise      = 1'b1;
                        n_state         = ST_DIV;
                    end else if (i_status.direct || i_status.per_zero) begin
                        o_cmd.zero_res = 1'b1;
                        n_state        = ST_DONE;
                    end else begin
                        o_cmd.div_start = 1'b1;
                        n_is_noise      = 1'b0;
                        n_state         = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = r_is_noise ? ST_NZ : ST_W1;
                end
            end
            ST_NZ: begin
                o_cmd.noise_fin = 1'b1;
                n_state         = ST_DONE;
            end
            ST_W1: begin
                o_cmd.w1 = 1'b1;
                n_state  = ST_W2;
            end
            ST_W2: begin
                o_cmd.w2 = 1'b1;
                n_state  = ST_W3;
            end
            ST_W3: begin
                o_cmd.w3 = 1'b1;
                n_state  = ST_W4;
            end
            ST_W4: begin
                o_cmd.w4 = 1'b1;
                n_state  = ST_DONE;
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_is_noise <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_is_noise <= n_is_noise;
        end
    end
endmodule

// ----- hw/rtl/psg_channel_wave_noise_generator_core.sv -----
// Top level of one sound channel with waveform table and noise source.
//
//  Channel | Direction | Handshake                  | Payload
//  in      | input     | i_in_valid / o_in_ready    | i_kind, i_wave_addr, i_wave_value
//  out     | output    | o_out_valid / i_out_ready  | o_left_sample, o_right_sample
//  cfg     | input     | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// A table write item writes the table when taken. A sample item in noise mode uses
// the 25-step serial divider and the noise update, in wave mode the divider and the
// scaling stages. A silent sample item skips both. Reset is synchronous and active low.
// A result waits in the output register; the next item is taken once it is loaded.
module psg_channel_wave_noise_generator_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_kind,
    input  logic [4:0]        i_wave_addr,
    input  logic [4:0]        i_wave_value,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic signed [7:0] o_left_sample,
    output logic signed [7:0] o_right_sample,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [16:0]       i_cfg_data
);
    psgc_pkg::t_cmd    cmd;
    psgc_pkg::t_status status;

    psgc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    psgc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_wave_addr    (i_wave_addr),
        .i_wave_value   (i_wave_value),
        .i_out_ready    (i_out_ready),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_out_valid    (o_out_valid),
        .o_left_sample  (o_left_sample),
        .o_right_sample (o_right_sample)
    );

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !i_kind && !o_out_valid) |=> !o_out_valid)
        else $error("A table write item produced a result.");

    a_div_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_start |=> !o_in_ready)
        else $error("Input taken while the divider started.");

    a_ready_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !status.div_busy)
        else $error("Input ready while the divider is busy.");
endmodule

// ----- tb/sv/tb_psg_channel_wave_noise_generator_core.sv -----
// Self-checking testbench of the sound channel core: table writes, wave, noise, silence.
module tb_psg_channel_wave_noise_generator_core;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic       kind;
        logic [4:0] addr;
        logic [4:0] value;
    } t_item;

    typedef struct packed {
        logic signed [7:0] left;
        logic signed [7:0] right;
    } t_pair;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic              i_kind;
    logic [4:0]        i_wave_addr;
    logic [4:0]        i_wave_value;
    logic              o_out_valid;
    logic              i_out_ready;
    logic signed [7:0] o_left_sample;
    logic signed [7:0] o_right_sample;
    logic              i_cfg_we;
    logic [2:0]        i_cfg_idx;
    logic [16:0]       i_cfg_data;

    psg_channel_wave_noise_generator_core DUT (.*);

    logic [11:0] m_period;
    logic [7:0]  m_ctrl, m_bal, m_noise, m_mvol;
    logic        m_stereo;
    logic [8:0]  m_ratio;
    logic [16:0] m_rate;
    logic [4:0]  m_table [32];
    logic [20:0] m_phase;
    logic [4:0]  m_pos;
    logic [16:0] m_nacc;
    logic [31:0] m_lfsr;
    logic [1:0]  m_pol;

    t_item pending_items[$];
    t_pair expected_samples[$];
    int    errors = 0;
    bit    sender_on = 0;
    int    gap_left = 0;
    int    burst_left = 0;
    int    stall_mode = 0;

    function automatic int unsigned level_of(input int unsigned idx);
        int unsigned t [32] = '{0, 1, 1, 2, 2, 2, 3, 3, 4, 4, 5, 5, 6, 7, 8, 9,
                                10, 11, 13, 15, 17, 19, 21, 24, 27, 31, 35, 39, 44, 50, 56, 64};
        return t[idx];
    endfunction

    function automatic int unsigned nib2(input logic [7:0] x);
        int unsigned a;
        int unsigned b;
        a = (x >> 3) & 5'h1E;
        b = (x << 1) & 5'h1E;
        return (a > b) ? a : b;
    endfunction

    task automatic channel_sample(input t_item it);
        int          left;
        int          right;
        int unsigned v, vol, rate, sum, steps, inc, lb, rb;
        int          s, lev;
        left = 0;
        right = 0;
        if (it.kind == 1'b0) begin
            m_table[it.addr] = it.value;
            return;
        end
        if (!m_ctrl[7]) begin
            m_phase = '0;
        end else if (psgc_pkg::NOISE_CAPABLE != 0 && m_noise[7]) begin
            rate = (m_rate == 0) ? 1 : m_rate;
            v = nib2(m_mvol) + m_ctrl[4:0] + nib2(m_bal);
            vol = level_of(v > 60 ? ((v - 60) & 5'h1F) : 0);
            sum = m_nacc + 3000 + m_noise[4:0] * 512;
            steps = sum / rate;
            if (steps >= 1) begin
                if (m_lfsr[19]) begin
                    m_lfsr = ((m_lfsr ^ 32'h4) << 1) + 1;
                    m_pol = psgc_pkg::POL_NEG;
                end else begin
                    m_lfsr = m_lfsr << 1;
                    m_pol = psgc_pkg::POL_POS;
                end
                sum = sum - rate * steps;
            end
            m_nacc = sum[16:0];
            lev = (m_pol == psgc_pkg::POL_POS) ? 7020 :
                  (m_pol == psgc_pkg::POL_NEG) ? -7020 : 0;
            left = (lev * int'(vol)) / 4096;
            right = left;
        end else if (m_ctrl[6]) begin
        end else if (m_period > 0) begin
            vol = m_ctrl[4:0];
            lb = (m_bal[7:4] * 11 * vol) / 10;
            rb = (m_bal[3:0] * 11 * vol) / 10;
            s = int'(m_table[m_pos]) - 16;
            if (s >= 0) s++;
            inc = (m_ratio << 16) / m_period;
            if (m_stereo) begin
                left = (s * int'(lb)) / 100;
                right = (s * int'(rb)) / 100;
            end else begin
                left = (s * int'((lb + rb) / 2)) / 100;
                right = 0;
            end
            m_phase = m_phase + inc[20:0];
            m_pos = m_phase[20:16];
        end
        expected_samples.push_back('{left[7:0], right[7:0]});
    endtask

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            channel_sample(t_item'{i_kind, i_wave_addr, i_wave_value});
            void'(pending_items.pop_front());
        end
        if (!(i_in_valid && !o_in_ready)) begin
            if (gap_left > 0) gap_left <= gap_left - 1;
            if (sender_on && pending_items.size() > 0
                && (gap_left == 0 || burst_left > 0)) begin
                t_item nx;
                nx = pending_items[0];
                i_in_valid <= 1'b1;
                {i_kind, i_wave_addr, i_wave_value} <= nx;
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(0, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready) begin
            if (expected_samples.size() == 0) begin
                $error("unexpected sample left=%0d right=%0d", o_left_sample, o_right_sample);
                errors++;
            end else begin
                t_pair e;
                e = expected_samples.pop_front();
                if (e.left !== o_left_sample) begin
                    $error("left_sample expected %0d actual %0d", e.left, o_left_sample);
                    errors++;
                end
                if (e.right !== o_right_sample) begin
                    $error("right_sample expected %0d actual %0d", e.right, o_right_sample);
                    errors++;
                end
            end
        end
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= ($urandom_range(0, 3) != 0);
            default: i_out_ready <= ($urandom_range(0, 3) == 0);
        endcase
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    end

    task automatic write_reg(input logic [2:0] idx, input logic [16:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            psgc_pkg::CFG_PERIOD:   m_period = data[11:0];
            psgc_pkg::CFG_CTRL:     m_ctrl = data[7:0];
            psgc_pkg::CFG_BALANCE:  m_bal = data[7:0];
            psgc_pkg::CFG_NOISE:    m_noise = data[7:0];
            psgc_pkg::CFG_MAIN_VOL: m_mvol = data[7:0];
            psgc_pkg::CFG_STEREO:   m_stereo = data[0];
            psgc_pkg::CFG_RATIO:    m_ratio = data[8:0];
            default:                m_rate = data;
        endcase
    endtask

    task automatic run_items();
        sender_on = 1;
        while (pending_items.size() > 0 || i_in_valid) @(posedge i_clk);
        sender_on = 0;
        while (expected_samples.size() > 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic add_items(input int n, input int write_pct);
        t_item it;
        for (int k = 0; k < n; k++) begin
            it.kind = ($urandom_range(0, 99) >= write_pct);
            it.addr = $urandom;
            it.value = $urandom;
            pending_items.push_back(it);
        end
    endtask

    task automatic random_setup(input bit extreme);
        write_reg(psgc_pkg::CFG_PERIOD,
                  extreme ? ($urandom_range(0, 1) ? 12'hFFF : 12'd1)
                          : $urandom_range(0, 7) == 0 ? 0 : $urandom_range(1, 4095));
        write_reg(psgc_pkg::CFG_CTRL,
                  $urandom_range(0, 3) == 0 ? $urandom : {1'b1, 1'b0, 6'($urandom)});
        write_reg(psgc_pkg::CFG_BALANCE, extreme ? 8'hFF : 8'($urandom));
        write_reg(psgc_pkg::CFG_NOISE,
                  $urandom_range(0, 2) == 0 ? {1'b1, 7'($urandom)} : {1'b0, 7'($urandom)});
        write_reg(psgc_pkg::CFG_MAIN_VOL, extreme ? 8'hFF : 8'($urandom));
        write_reg(psgc_pkg::CFG_STEREO, $urandom_range(0, 1));
        write_reg(psgc_pkg::CFG_RATIO,
                  extreme ? ($urandom_range(0, 1) ? 448 : 37) : $urandom_range(37, 448));
        write_reg(psgc_pkg::CFG_RATE,
                  $urandom_range(0, 9) == 0 ? ($urandom_range(0, 1) ? 17'h1FFFF : 0)
                                            : $urandom_range(8000, 96000));
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_kind = 1'b0;
        i_wave_addr = '0;
        i_wave_value = '0;
        i_out_ready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        m_period = 0; m_ctrl = 0; m_bal = 0; m_noise = 0; m_mvol = 0;
        m_stereo = 1; m_ratio = 81; m_rate = 44100;
        foreach (m_table[k]) m_table[k] = '0;
        m_phase = 0; m_pos = 0; m_nacc = 0; m_lfsr = psgc_pkg::NOISE_SEED;
        m_pol = psgc_pkg::POL_SILENT;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        pending_items.push_back('{1'b1, 5'd0, 5'd0});
        for (int k = 0; k < 32; k += 3)
            pending_items.push_back('{1'b0, 5'(k), 5'(k % 2 ? 31 : k)});
        pending_items.push_back('{1'b0, 5'd31, 5'd31});
        pending_items.push_back('{1'b0, 5'd1, 5'd0});
        run_items();
        write_reg(psgc_pkg::CFG_CTRL, 8'h9F);
        write_reg(psgc_pkg::CFG_BALANCE, 8'hFF);
        write_reg(psgc_pkg::CFG_PERIOD, 12'd1);
        write_reg(psgc_pkg::CFG_RATIO, 9'd448);
        for (int k = 0; k < 4; k++) pending_items.push_back('{1'b1, 5'd0, 5'd0});
        run_items();
        write_reg(psgc_pkg::CFG_STEREO, 1'b0);
        write_reg(psgc_pkg::CFG_PERIOD, 12'd0);
        pending_items.push_back('{1'b1, 5'd0, 5'd0});
        run_items();
        write_reg(psgc_pkg::CFG_CTRL, 8'hDF);
        pending_items.push_back('{1'b1, 5'd0, 5'd0});
        run_items();
        write_reg(psgc_pkg::CFG_NOISE, 8'h9F);
        write_reg(psgc_pkg::CFG_MAIN_VOL, 8'hFF);
        write_reg(psgc_pkg::CFG_RATE, 17'd0);
        for (int k = 0; k < 4; k++) pending_items.push_back('{1'b1, 5'd0, 5'd0});
        run_items();
        write_reg(psgc_pkg::CFG_CTRL, 8'h1F);
        pending_items.push_back('{1'b1, 5'd0, 5'd0});
        run_items();

        for (int ph = 0; ph < 24; ph++) begin
            random_setup(ph < 4);
            add_items(80, 25);
            run_items();
        end

        if (errors == 0) begin
            $display("psg_channel_wave_noise_generator_core test passed");
        end else begin
            $display("psg_channel_wave_noise_generator_core test failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("psg_channel_wave_noise_generator_core test failed");
        $finish;
    end
endmodule
